/* rtl/core/mlfd_pkg.sv */
// ----------------------------------------------------------------------------
// Magic/length deframer package
// Shared result type, byte tag codes and the fixed magic string.
// ----------------------------------------------------------------------------
package mlfd_pkg;

    // Width of the counter that walks the frame; a body can be as long as a
    // full 32-bit length plus an 8-bit tail.
    localparam int COUNT_W      = 33;
    localparam int LEN_W        = 32;
    localparam int TAIL_W       = 8;
    localparam int MAGIC_IDX_W  = 3;
    localparam int MAGIC_MAX    = 8;

    typedef enum logic [1:0] {
        KIND_HEADER   = 2'd0,
        KIND_BODY     = 2'd1,
        KIND_BADMAGIC = 2'd2,
        KIND_DROPPED  = 2'd3
    } mlfd_kind_t;

    typedef struct packed {
        logic [7:0]       data;
        mlfd_kind_t       kind;
        logic             last;
        logic [LEN_W-1:0] length;
    } mlfd_result_t;

    typedef struct packed {
        logic corrupt;
    } mlfd_status_t;

    // The eight magic characters, first byte at index zero.
    function automatic logic [7:0] magic_byte(input logic [MAGIC_IDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h54;
            3'd1:    b = 8'h4D;
            3'd2:    b = 8'h32;
            3'd3:    b = 8'h30;
            3'd4:    b = 8'h31;
            3'd5:    b = 8'h31;
            3'd6:    b = 8'h43;
            3'd7:    b = 8'h31;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* rtl/core/magic_length_frame_deframer.sv */
// ----------------------------------------------------------------------------
// Magic/length frame deframer
// Tags a byte stream as magic/length header, body or dropped bytes.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Beat contents
//  -------   ---------  -------------------  ----------------------------------
//  in        sink       in_valid / in_stall  in_byte
//  out       source     out_valid/out_stall  out_byte, byte_kind,
//                                            last_of_frame, frame_length
//  cfg       sink       cfg_wr_en            cfg_wr_data (tail byte count)
//
//  Every input beat produces exactly one output beat. A beat is parsed in the
//  cycle it is accepted and its result is registered in the output buffer.
//  With the output never stalled the block takes one beat per clock; the
//  single parse stage and its 33-bit add and compare set that figure.
//  Reset puts the parser back to waiting for magic and sets the tail count to
//  twenty. The skid stage lets the input keep flowing for one beat after the
//  output stalls; in_stall rises only once both result slots hold data.
//
//  Frames open with the magic string, then a big-endian length field, then a
//  body of length plus tail bytes. A bad magic makes the block drop every
//  following beat until reset, tagging them as dropped.
// ----------------------------------------------------------------------------
module magic_length_frame_deframer #(
    parameter int MAGIC_BYTES  = 8,
    parameter int LENGTH_BYTES = 4
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic [1:0]  byte_kind,
    output logic        last_of_frame,
    output logic [31:0] frame_length,

    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);

    logic [mlfd_pkg::TAIL_W-1:0]  tail_reg;
    logic                         in_accept;
    mlfd_pkg::mlfd_result_t       parse_result;
    mlfd_pkg::mlfd_result_t       out_data;
    mlfd_pkg::mlfd_status_t       status;
    logic                         buf_full;

    // The tail count is a plain register; the user must write it only while idle, the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_reg <= 8'd20;
        end
        else if (cfg_wr_en)
        begin
            tail_reg <= cfg_wr_data;
        end
    end

    assign in_stall  = buf_full;
    assign in_accept = in_valid & ~buf_full;

    // Frame state and byte tagging.
    mlfd_parser #(
        .MAGIC_BYTES  (MAGIC_BYTES),
        .LENGTH_BYTES (LENGTH_BYTES)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_accept),
        .in_byte    (in_byte),
        .tail_bytes (tail_reg),
        .result     (parse_result),
        .status     (status)
    );

    // Result register plus skid slot.
    mlfd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_data (parse_result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign out_byte      = out_data.data;
    assign byte_kind     = out_data.kind;
    assign last_of_frame = out_data.last;
    assign frame_length  = out_data.length;

    // Once corrupt, the parser never leaves that phase before reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.corrupt |=> status.corrupt)
        else $error("corrupt phase was left without reset");

    // The end-of-frame mark only ever rides on a body byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_of_frame) |-> (byte_kind == mlfd_pkg::KIND_BODY))
        else $error("last_of_frame set on a non-body byte");

    // The skid slot fills only behind a valid result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with an empty result register");

    // A bad-magic tag leaves the parser in the corrupt phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && parse_result.kind == mlfd_pkg::KIND_BADMAGIC) |=> status.corrupt)
        else $error("magic failure did not enter corrupt phase");

endmodule

/* rtl/core/mlfd_parser.sv */
// ----------------------------------------------------------------------------
// Deframer parser
// Holds the frame state and tags each accepted byte in a single pass.
// ----------------------------------------------------------------------------
module mlfd_parser #(
    parameter int MAGIC_BYTES  = 8,
    parameter int LENGTH_BYTES = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic [7:0]                     in_byte,
    input  logic [mlfd_pkg::TAIL_W-1:0]    tail_bytes,
    output mlfd_pkg::mlfd_result_t         result,
    output mlfd_pkg::mlfd_status_t         status
);

    typedef enum logic [1:0] {
        PH_MAGIC   = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_BODY    = 2'd2,
        PH_CORRUPT = 2'd3
    } phase_t;

    localparam logic [mlfd_pkg::COUNT_W-1:0] MAGIC_END  = mlfd_pkg::COUNT_W'(MAGIC_BYTES);
    localparam logic [mlfd_pkg::COUNT_W-1:0] LENGTH_END = mlfd_pkg::COUNT_W'(LENGTH_BYTES);

    phase_t                          phase_reg,  phase_next;
    logic [mlfd_pkg::COUNT_W-1:0]    count_reg,  count_next;
    logic                            match_reg,  match_next;
    logic [mlfd_pkg::LEN_W-1:0]      len_reg,    len_next;

    logic [mlfd_pkg::COUNT_W-1:0]    count_inc;
    logic [mlfd_pkg::LEN_W-1:0]      len_shift;
    logic [mlfd_pkg::LEN_W-1:0]      add_len;
    logic [mlfd_pkg::COUNT_W-1:0]    total;
    logic                            match_now;

    assign count_inc = count_reg + 1'b1;
    assign len_shift = {len_reg[mlfd_pkg::LEN_W-9:0], in_byte};
    // One adder serves both the end-of-header check and the body end.
    assign add_len   = (phase_reg == PH_LENGTH) ? len_shift : len_reg;
    assign total     = {1'b0, add_len}
                     + {{(mlfd_pkg::COUNT_W-mlfd_pkg::TAIL_W){1'b0}}, tail_bytes};
    assign match_now = match_reg
                     & (in_byte == mlfd_pkg::magic_byte(count_reg[mlfd_pkg::MAGIC_IDX_W-1:0]));

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        match_next  = match_reg;
        len_next    = len_reg;
        result.data = in_byte;
        result.kind = mlfd_pkg::KIND_HEADER;
        result.last = 1'b0;

        case (phase_reg)
            PH_MAGIC:
            begin
                if (count_reg == '0)
                begin
                    len_next = '0;
                end
                match_next = match_now;
                if (count_inc >= MAGIC_END)
                begin
                    count_next = '0;
                    if (match_now)
                    begin
                        phase_next = PH_LENGTH;
                    end
                    else
                    begin
                        phase_next  = PH_CORRUPT;
                        result.kind = mlfd_pkg::KIND_BADMAGIC;
                    end
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            PH_LENGTH:
            begin
                len_next = len_shift;
                if (count_inc >= LENGTH_END)
                begin
                    count_next = '0;
                    if (total == '0)
                    begin
                        phase_next = PH_MAGIC;
                        match_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_BODY;
                    end
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            PH_BODY:
            begin
                result.kind = mlfd_pkg::KIND_BODY;
                if (count_inc >= total)
                begin
                    result.last = 1'b1;
                    phase_next  = PH_MAGIC;
                    count_next  = '0;
                    match_next  = 1'b1;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            default:
            begin
                result.kind = mlfd_pkg::KIND_DROPPED;
            end
        endcase

        result.length = len_next;
    end

    assign status.corrupt = (phase_reg == PH_CORRUPT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MAGIC;
            count_reg <= '0;
            match_reg <= 1'b1;
            len_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            match_reg <= match_next;
            len_reg   <= len_next;
        end
    end

endmodule

/* rtl/core/mlfd_out_buf.sv */
// ----------------------------------------------------------------------------
// Deframer result buffer
// Result register with a skid stage so input and output stalls stay apart.
// ----------------------------------------------------------------------------
module mlfd_out_buf (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  mlfd_pkg::mlfd_result_t  push_data,
    output logic                    full,
    output logic                    out_valid,
    input  logic                    out_stall,
    output mlfd_pkg::mlfd_result_t  out_data
);

    logic                    main_valid_reg;
    logic                    skid_valid_reg;
    mlfd_pkg::mlfd_result_t  main_reg;
    mlfd_pkg::mlfd_result_t  skid_reg;
    logic                    pop;

    assign pop       = main_valid_reg & ~out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else if (!push)
            begin
                main_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
            end
            else if (push)
            begin
                main_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_reg <= push_data;
            end
            else
            begin
                main_reg <= push_data;
            end
        end
    end

endmodule

/* test/magic_length_frame_deframer_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Magic/length frame deframer testbench
// Feeds framed byte streams through the deframer, predicts the tag of every
// beat in a local model of the parser and compares each output beat field by
// field, under random input gaps, output stalls and tail count changes.
// ----------------------------------------------------------------------------
module magic_length_frame_deframer_test;

    import mlfd_pkg::*;

    localparam int MAGIC_BYTES  = 8;
    localparam int LENGTH_BYTES = 4;
    // The magic string, first byte in the top eight bits.
    localparam logic [63:0] MAGIC_SEQ = 64'h544D_3230_3131_4331;
    // Cycles without any beat moving on either side before the run is abandoned.
    localparam int QUIET_LIMIT = 2000;

    // Where the parser stands inside a frame.
    typedef enum logic [1:0] {
        PH_MAGIC   = 2'd0,
        PH_LEN     = 2'd1,
        PH_BODY    = 2'd2,
        PH_CORRUPT = 2'd3
    } parse_phase_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic [1:0]  byte_kind;
    logic        last_of_frame;
    logic [31:0] frame_length;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'd0;

    // Bytes waiting to be offered, and the tags predicted for accepted bytes.
    logic [7:0]   stream_q[$];
    mlfd_result_t expected_tags[$];

    // Local copy of the parser state and of the tail count register.
    parse_phase_t parse_ph = PH_MAGIC;
    logic [32:0]  seg_count = '0;
    logic         magic_ok = 1'b1;
    logic [31:0]  len_acc = '0;
    logic [7:0]   tail_cfg = 8'd20;

    int src_gap_pct   = 0;
    int dst_stall_pct = 0;
    int n_queued      = 0;
    int mismatches    = 0;
    int frames_closed = 0;
    int dropped_beats = 0;
    int tail_writes   = 0;
    int beats_checked = 0;
    int quiet_cycles  = 0;

    magic_length_frame_deframer #(
        .MAGIC_BYTES  (MAGIC_BYTES),
        .LENGTH_BYTES (LENGTH_BYTES)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .byte_kind     (byte_kind),
        .last_of_frame (last_of_frame),
        .frame_length  (frame_length),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advances the local parser by one byte and returns the tag the block
    // should attach to it. The body size is always judged against the tail
    // count in force now, so a tail change in the middle of a body is seen.
    function automatic mlfd_result_t tag_byte(input logic [7:0] b);
        mlfd_result_t r;
        logic [32:0]  body_total;
        r.data = b;
        r.kind = KIND_HEADER;
        r.last = 1'b0;
        case (parse_ph)
            PH_MAGIC:
            begin
                // A new frame clears the length shown on the output.
                if (seg_count == 0)
                    len_acc = '0;
                if (b != MAGIC_SEQ[63 - 8 * seg_count[2:0] -: 8])
                    magic_ok = 1'b0;
                seg_count++;
                if (seg_count >= MAGIC_BYTES)
                begin
                    seg_count = '0;
                    if (magic_ok)
                        parse_ph = PH_LEN;
                    else
                    begin
                        parse_ph = PH_CORRUPT;
                        r.kind = KIND_BADMAGIC;
                    end
                end
            end
            PH_LEN:
            begin
                len_acc = {len_acc[23:0], b};
                seg_count++;
                if (seg_count >= LENGTH_BYTES)
                begin
                    seg_count = '0;
                    body_total = {1'b0, len_acc} + {25'd0, tail_cfg};
                    // With nothing to carry, the frame closes on its header.
                    if (body_total == 0)
                    begin
                        parse_ph = PH_MAGIC;
                        magic_ok = 1'b1;
                    end
                    else
                        parse_ph = PH_BODY;
                end
            end
            PH_BODY:
            begin
                r.kind = KIND_BODY;
                seg_count++;
                body_total = {1'b0, len_acc} + {25'd0, tail_cfg};
                if (seg_count >= body_total)
                begin
                    r.last = 1'b1;
                    parse_ph = PH_MAGIC;
                    seg_count = '0;
                    magic_ok = 1'b1;
                end
            end
            default:
                r.kind = KIND_DROPPED;
        endcase
        r.length = len_acc;
        return r;
    endfunction

    // Input side. A beat stays on the bus until it is taken; a new one is put
    // up only when the bus is free or the current beat is being accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte  <= 8'd0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_tags.push_back(tag_byte(in_byte));
            if (!in_valid || !in_stall)
            begin
                if (stream_q.size() != 0 && $urandom_range(99) >= src_gap_pct)
                begin
                    in_valid <= 1'b1;
                    in_byte  <= stream_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output side. Every beat taken is checked against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : result_check
        mlfd_result_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                beats_checked++;
                if (expected_tags.size() == 0)
                begin
                    $error("beat with no prediction waiting: out_byte %0h", out_byte);
                    mismatches++;
                end
                else
                begin
                    want = expected_tags.pop_front();
                    if (out_byte !== want.data)
                    begin
                        $error("out_byte: expected %0h, got %0h", want.data, out_byte);
                        mismatches++;
                    end
                    if (byte_kind !== want.kind)
                    begin
                        $error("byte_kind: expected %0d, got %0d", want.kind, byte_kind);
                        mismatches++;
                    end
                    if (last_of_frame !== want.last)
                    begin
                        $error("last_of_frame: expected %0b, got %0b",
                               want.last, last_of_frame);
                        mismatches++;
                    end
                    if (frame_length !== want.length)
                    begin
                        $error("frame_length: expected %0h, got %0h",
                               want.length, frame_length);
                        mismatches++;
                    end
                    if (want.last)
                        frames_closed++;
                    if (want.kind == KIND_DROPPED)
                        dropped_beats++;
                end
            end
            out_stall <= ($urandom_range(99) < dst_stall_pct);
        end
    end

    // Watchdog: a run where nothing moves for too long has hung.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Waits until every queued byte went in and every predicted beat came
    // out. Sampled on the falling edge so that all rising-edge updates of the
    // same cycle have settled.
    task automatic wait_drained();
        @(negedge clk);
        while (stream_q.size() != 0 || in_valid || expected_tags.size() != 0)
            @(negedge clk);
    endtask

    // The tail register is only written with the block idle. The parser may
    // still sit in the middle of a body, which is how a tail change
    // mid-frame is reached.
    task automatic write_tail(input logic [7:0] value);
        wait_drained();
        repeat (2) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        tail_cfg = value;
        tail_writes++;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push_byte(input logic [7:0] b);
        stream_q.push_back(b);
        n_queued++;
    endtask

    task automatic push_header(input logic [31:0] len);
        for (int i = 0; i < MAGIC_BYTES; i++)
            push_byte(MAGIC_SEQ[63 - 8 * i -: 8]);
        for (int i = LENGTH_BYTES - 1; i >= 0; i--)
            push_byte(len[8 * i +: 8]);
    endtask

    task automatic push_body(input int count);
        for (int i = 0; i < count; i++)
            push_byte(8'($urandom_range(255)));
    endtask

    // Mostly short tails; now and then the range ends, and the zero value
    // that the register accepts even though frames are not meant to use it.
    function automatic logic [7:0] pick_tail();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return 8'd0;
        else if (r < 9)
            return 8'd255;
        else
            return 8'($urandom_range(12, 1));
    endfunction

    // Mostly short lengths, some zero, a few with the length's second byte set.
    function automatic logic [31:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 12)
            return 32'd0;
        else if (r < 16)
            return {16'd0, 8'd1, 8'($urandom_range(255))};
        else
            return $urandom_range(24, 1);
    endfunction

    // Queues one well-formed frame. With a retune the tail count is changed
    // after part of the body has gone through; the rest of the body then
    // follows the new count, and one byte ends it if the count is already met.
    task automatic send_frame(input logic [31:0] len, input bit retune);
        int total;
        int part;
        push_header(len);
        total = int'(len) + int'(tail_cfg);
        if (retune && total > 1)
        begin
            part = $urandom_range(total - 1, 1);
            push_body(part);
            write_tail(pick_tail());
            total = int'(len) + int'(tail_cfg);
            push_body(part >= total ? 1 : total - part);
        end
        else
            push_body(total);
    endtask

    task automatic run_frames(input int target);
        while (n_queued < target)
        begin
            if ($urandom_range(4) == 0)
                write_tail(pick_tail());
            send_frame(pick_length(), $urandom_range(9) == 0);
        end
        wait_drained();
    endtask

    initial
    begin
        int bad_pos;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Sender gaps are rare, the receiver stalls most of the time.
        src_gap_pct   = 15;
        dst_stall_pct = 79;

        // A zero-length frame under the reset tail count, cut short after
        // three body bytes; the tail then drops below the count already
        // reached, so the very next body byte has to close the frame.
        push_header(32'd0);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'($urandom_range(255)));
        write_tail(8'd2);
        push_byte(8'hA5);

        // Zero tail with zero length: the frame ends on its last header byte.
        write_tail(8'd0);
        push_header(32'd0);

        // Longest tail the register holds.
        write_tail(8'd255);
        send_frame(32'd0, 1'b0);
        write_tail(8'd1);
        run_frames(n_queued + 110);

        // Swap the pressure: the sender idles, the receiver rarely stalls.
        src_gap_pct   = 79;
        dst_stall_pct = 15;
        run_frames(n_queued + 130);

        // Full rate on both sides.
        src_gap_pct   = 0;
        dst_stall_pct = 0;
        run_frames(n_queued + 130);

        // Finally a magic with one wrong byte; the block goes corrupt and
        // must drop everything that follows, since only reset brings it back.
        bad_pos = $urandom_range(MAGIC_BYTES - 1);
        for (int i = 0; i < MAGIC_BYTES; i++)
            if (i == bad_pos)
                push_byte(MAGIC_SEQ[63 - 8 * i -: 8] ^ 8'($urandom_range(255, 1)));
            else
                push_byte(MAGIC_SEQ[63 - 8 * i -: 8]);
        push_body(24);

        wait_drained();
        repeat (8) @(posedge clk);

        $display("Run covered %0d beats in %0d closed frames over %0d tail settings,",
                 beats_checked, frames_closed, tail_writes);
        $display("ending with a bad magic and %0d beats dropped as corrupt.",
                 dropped_beats);
        if (mismatches == 0 && expected_tags.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
